[rtl/pal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

	// Store geometry defaults.
	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed widths of the stream fields.
	localparam int ACTION_W   = 2;
	localparam int POSITION_W = 7;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 3;
	localparam int FOUND_W    = 6;
	localparam int LENGTH_W   = 7;
	localparam int CAP_W      = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Requested operations.
	localparam logic [ACTION_W-1:0] ACT_GET    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

	// Entries handled by one leaf of the search tree.
	localparam int GROUP = 8;

	// Operation strobes broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
		logic get;
		logic find;
	} pal_op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_TREE = 3'b100
	} pal_state_t;

endpackage

`default_nettype wire

[rtl/pal_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module pal_cell import pal_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int WW         = 7,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire pal_op_t               op,
	input  wire logic [WW-1:0]         pos,
	input  wire logic [WW-1:0]         count,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [VALUE_BITS-1:0] left_data,
	input  wire logic [VALUE_BITS-1:0] right_data,
	output logic      [VALUE_BITS-1:0] data,
	output logic                       match,
	output logic      [VALUE_BITS-1:0] rd_data
);

	localparam logic [WW-1:0] K  = WW'(INDEX);
	localparam logic [WW-1:0] K1 = WW'(INDEX + 1);

	logic [VALUE_BITS-1:0] data_q;
	logic                  in_list;
	logic                  load;
	logic [VALUE_BITS-1:0] nxt;

	assign in_list = (K < count);

	always_comb begin
		load = 1'b0;
		nxt  = left_data;
		if (op.ins) begin
			if (K == pos) begin
				load = 1'b1;
				nxt  = value;
			end else if ((K > pos) && (K <= count)) begin
				load = 1'b1;
				nxt  = left_data;
			end
		end else if (op.rem) begin
			if ((K >= pos) && (K1 < count)) begin
				load = 1'b1;
				nxt  = right_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt;
		end
	end

	assign data    = data_q;
	assign match   = op.find && in_list && (data_q == value);
	assign rd_data = (op.get && in_list && (K == pos)) ? data_q : '0;

endmodule

`default_nettype wire

[rtl/pal_find.sv]
`timescale 1ns / 1ps
`default_nettype none

module pal_find import pal_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [DEPTH-1:0]                  match,
	input  wire logic [DEPTH-1:0][VALUE_BITS-1:0]  rd_data,
	output logic                                   any,
	output logic      [$clog2(DEPTH)-1:0]          index,
	output logic      [VALUE_BITS-1:0]             rd_value
);

	localparam int IW = $clog2(DEPTH);
	localparam int NG = (DEPTH + GROUP - 1) / GROUP;
	localparam int LW = $clog2(GROUP);

	logic [NG*GROUP-1:0]                 match_pad;
	logic [NG*GROUP-1:0][VALUE_BITS-1:0] data_pad;

	logic [NG-1:0]                 grp_any;
	logic [NG-1:0][LW-1:0]         grp_idx;
	logic [NG-1:0][VALUE_BITS-1:0] grp_val;

	logic [NG-1:0]                 any_s1;
	logic [NG-1:0][LW-1:0]         idx_s1;
	logic [NG-1:0][VALUE_BITS-1:0] val_s1;

	always_comb begin
		match_pad = '0;
		data_pad  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match_pad[i] = match[i];
			data_pad[i]  = rd_data[i];
		end
	end

	// Leaf level: lowest match and OR of the selected word inside each group.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			grp_val[g] = '0;
			for (int l = GROUP - 1; l >= 0; l--) begin
				grp_val[g] = grp_val[g] | data_pad[g*GROUP + l];
				if (match_pad[g*GROUP + l]) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = LW'(l);
				end
			end
		end
	end

	// The leaf results are held until the next request is compared.
	always_ff @(posedge clk) begin
		if (en) begin
			any_s1 <= grp_any;
			idx_s1 <= grp_idx;
			val_s1 <= grp_val;
		end
	end

	// Root level: the lowest group with a match wins.
	always_comb begin
		any      = 1'b0;
		index    = '0;
		rd_value = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			rd_value = rd_value | val_s1[g];
			if (any_s1[g]) begin
				any   = 1'b1;
				index = IW'(g*GROUP + int'(idx_s1[g]));
			end
		end
	end

endmodule

`default_nettype wire

[rtl/positional_array_list.sv]
// Positional array list: an ordered list of values held in a row of DEPTH
// storage cells, each cell owning one entry and talking to its two neighbours.
//
// Requests arrive on the s_axis channel: tuser carries the action (get, find,
// insert, remove) and tdata carries the position and the value. Every request
// produces exactly one word on the m_axis channel: tuser carries the status and
// tdata carries the read value, the found position and the new list length.
// The cfg channel writes the capacity register; it is always ready and is
// meant to be written only while no request is in flight.
//
// A request is accepted when the block is idle. It then passes through the
// compare state, in which the cells compare and shift together and the leaf
// level of the search tree is registered, and the tree state, through the root
// of the tree into the output register. The block returns to idle as the
// result is loaded, so no new request is taken before that. The output register
// decouples the receiver: while a result waits for m_axis_tready the block
// still accepts and works on the next request, and only holds its result
// stage until the output register is free again.
//
// Reset clears the list length, restores the capacity to 64 and empties the
// output register; the entry contents are not cleared and are never read
// before they have been written.

`timescale 1ns / 1ps
`default_nettype none

module positional_array_list import pal_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: position [6:0], value [38:7], zero [39]
	input  wire logic [39:0] s_axis_tdata,
	// tuser: action [1:0]
	input  wire logic [1:0]  s_axis_tuser,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: read_value [31:0], found_position [37:32], list_length [44:38],
	// zero [47:45]
	output logic      [47:0] m_axis_tdata,
	// tuser: status [2:0]
	output logic      [2:0]  m_axis_tuser,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > POSITION_W) ? CW : POSITION_W;
	localparam int IW = $clog2(DEPTH);
	localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

	pal_state_t state_q;

	logic [ACTION_W-1:0]   act_q;
	logic [WW-1:0]         pos_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [CAP_W-1:0]      cap_q;
	logic [STATUS_W-1:0]   status_s1;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [FOUND_W-1:0]    out_found_q;
	logic [LENGTH_W-1:0]   out_length_q;

	logic                  in_acc;
	logic                  out_free;
	logic [WW-1:0]         count_w;
	logic [WW-1:0]         cap_w;
	logic [WW-1:0]         eff_cap;
	logic [STATUS_W-1:0]   status_c;
	pal_op_t               op;

	logic [DEPTH-1:0][VALUE_BITS-1:0] cell_data;
	logic [DEPTH-1:0][VALUE_BITS-1:0] cell_rd;
	logic [DEPTH-1:0]                 cell_match;

	logic                  hit;
	logic [IW-1:0]         hit_index;
	logic [VALUE_BITS-1:0] hit_value;
	logic [STATUS_W-1:0]   status_fin;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Capacity above the store depth is limited to the depth.
	assign count_w = WW'(count_q);
	assign cap_w   = WW'(cap_q);
	assign eff_cap = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;

	// Status of the request, judged on the list as it stands before the change.
	always_comb begin
		status_c = STS_OK;
		case (act_q)
			ACT_GET: begin
				if (pos_q >= count_w) begin
					status_c = STS_BADPOS;
				end
			end
			ACT_FIND: begin
				status_c = STS_OK;
			end
			ACT_INSERT: begin
				if (count_w >= eff_cap) begin
					status_c = STS_FULL;
				end else if (pos_q > count_w) begin
					status_c = STS_BADPOS;
				end
			end
			ACT_REMOVE: begin
				if (count_w == '0) begin
					status_c = STS_EMPTY;
				end else if (pos_q >= count_w) begin
					status_c = STS_BADPOS;
				end
			end
			default: begin
				status_c = STS_OK;
			end
		endcase
	end

	always_comb begin
		op      = '0;
		op.ins  = (state_q == ST_EXEC) && (act_q == ACT_INSERT) && (status_c == STS_OK);
		op.rem  = (state_q == ST_EXEC) && (act_q == ACT_REMOVE) && (status_c == STS_OK);
		op.get  = (state_q == ST_EXEC) && (act_q == ACT_GET);
		op.find = (state_q == ST_EXEC) && (act_q == ACT_FIND);
	end

	// The row of cells: each one is fed by both neighbours for the shifts.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [VALUE_BITS-1:0] left_d;
		logic [VALUE_BITS-1:0] right_d;

		if (k == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[k+1];
		end

		pal_cell #(
			.VALUE_BITS (VALUE_BITS),
			.WW         (WW),
			.INDEX      (k)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos_q),
			.count      (count_w),
			.value      (val_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[k]),
			.match      (cell_match[k]),
			.rd_data    (cell_rd[k])
		);
	end

	// The leaf level is captured only in the compare cycle, so a result that
	// waits for the output register keeps its search outcome.
	pal_find #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_find (
		.clk      (clk),
		.en       (state_q == ST_EXEC),
		.match    (cell_match),
		.rd_data  (cell_rd),
		.any      (hit),
		.index    (hit_index),
		.rd_value (hit_value)
	);

	assign status_fin = (act_q == ACT_FIND) ? (hit ? STS_OK : STS_NOTFOUND) : status_s1;

	// Request register and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op.ins) begin
						count_q <= count_q + CW'(1);
					end else if (op.rem) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= ST_TREE;
				end
				ST_TREE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= s_axis_tuser;
			pos_q <= WW'(s_axis_tdata[6:0]);
			val_q <= VALUE_BITS'(s_axis_tdata[38:7]);
		end
		if (state_q == ST_EXEC) begin
			status_s1 <= status_c;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_TREE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_TREE) && out_free) begin
			out_status_q <= status_fin;
			out_value_q  <= VALUE_W'(hit_value);
			out_found_q  <= FOUND_W'(hit_index);
			out_length_q <= LENGTH_W'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'b000, out_length_q, out_found_q, out_value_q};

	// The list never grows past the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(count_q) <= DEPTH_W)
		else $error("list length beyond store depth");

	// A successful insert grows the list by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	// A refused request leaves the length alone.
	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && (status_c != STS_OK)) |=> $stable(count_q))
		else $error("refused request changed the length");

	// A non-zero read value only comes with a good status.
	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0)) |-> (m_axis_tuser == STS_OK))
		else $error("read value on a failed request");

	// A found entry lies inside the list.
	a_found_inside: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_TREE) && (act_q == ACT_FIND) && hit) |-> (WW'(hit_index) < count_w))
		else $error("found position outside the list");

endmodule

`default_nettype wire

[tb/tb_positional_array_list.sv]
`timescale 1ns / 1ps

// Testbench for the positional array list. A clocked driver feeds request words
// from a queue that the stimulus process fills phase by phase. A queue-based
// model of the list predicts one result word for every accepted request, and
// the monitor checks each result word field by field against the oldest
// prediction. The capacity register is rewritten only between phases, once
// every predicted result has come back.
module tb_positional_array_list;
	import pal_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;  // handshake-free cycles before giving up
	localparam int HOLD_CYCLES    = 400;   // length of the long receiver hold-off
	localparam int VAL_POOL       = 6;     // small value set so that finds hit
	localparam int ERR_PRINT_MAX  = 30;

	// One request as it travels on the slave side.
	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [POSITION_W-1:0] position;
		logic [VALUE_W-1:0]    value;
	} list_req_t;

	// One result as it comes back on the master side.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  read_value;
		logic [FOUND_W-1:0]  found_position;
		logic [LENGTH_W-1:0] list_length;
	} list_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata: position [6:0], value [38:7], zero [39]
	logic [39:0] s_axis_tdata = '0;
	// tuser: action [1:0]
	logic [1:0]  s_axis_tuser = ACT_GET;

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: read_value [31:0], found_position [37:32], list_length [44:38], zero [47:45]
	logic [47:0] m_axis_tdata;
	// tuser: status [2:0]
	logic [2:0]  m_axis_tuser;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	positional_array_list u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Model of the list: the queue holds the live entries in position order,
	// so its size is the list length.
	logic [VALUE_W-1:0] list_entries[$];
	int                 list_capacity = int'(CAP_RESET);
	int                 peak_length = 0;

	list_req_t pending_reqs[$];   // requests waiting to be offered
	list_res_t expected_res[$];   // predicted results, oldest first
	list_req_t offered_req;       // request currently on the slave side

	// Stimulus shaping: the generator keeps a rough idea of the list length so
	// that most positions land inside the list.
	int                 gen_len = 0;
	int                 gen_cap = DEPTH_DEF;
	logic [VALUE_W-1:0] val_pool[VAL_POOL];

	int send_idle_pct = 35;
	int recv_idle_pct = 48;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int err_count = 0;
	int req_count = 0;
	int res_count = 0;
	int action_seen[4];
	int status_seen[5];

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the result of one accepted request and advances the model.
	function automatic void predict_result(list_req_t r);
		list_res_t e;
		int        n;
		int        eff_cap;
		bit        hit;
		e = '0;
		n = list_entries.size();
		eff_cap = (list_capacity > DEPTH_DEF) ? DEPTH_DEF : list_capacity;
		case (r.action)
			ACT_GET: begin
				if (r.position >= n)
					e.status = STS_BADPOS;
				else
					e.read_value = list_entries[r.position];
			end
			ACT_FIND: begin
				// The first matching position wins, so duplicates report the lowest one.
				e.status = STS_NOTFOUND;
				hit = 1'b0;
				for (int k = 0; k < n; k++) begin
					if (!hit && list_entries[k] == r.value) begin
						hit = 1'b1;
						e.status = STS_OK;
						e.found_position = k[FOUND_W-1:0];
					end
				end
			end
			ACT_INSERT: begin
				// A full list is reported before the position is looked at.
				if (n >= eff_cap)
					e.status = STS_FULL;
				else if (r.position > n)
					e.status = STS_BADPOS;
				else
					list_entries.insert(r.position, r.value);
			end
			default: begin
				// Likewise an empty list is reported before a bad position.
				if (n == 0)
					e.status = STS_EMPTY;
				else if (r.position >= n)
					e.status = STS_BADPOS;
				else
					list_entries.delete(r.position);
			end
		endcase
		e.list_length = LENGTH_W'(list_entries.size());
		if (list_entries.size() > peak_length)
			peak_length = list_entries.size();
		expected_res.push_back(e);
	endfunction

	function automatic list_req_t make_request(int ins_pct, int rem_pct);
		list_req_t r;
		int        roll;
		int        span;
		roll = $urandom_range(99);
		if (roll < ins_pct)
			r.action = ACT_INSERT;
		else if (roll < ins_pct + rem_pct)
			r.action = ACT_REMOVE;
		else if (roll[0])
			r.action = ACT_GET;
		else
			r.action = ACT_FIND;
		// Mostly positions inside the list, some just past its end, some anywhere.
		span = (r.action == ACT_INSERT) ? gen_len : gen_len - 1;
		roll = $urandom_range(99);
		if (roll < 80 && span >= 0)
			r.position = POSITION_W'($urandom_range(span, 0));
		else if (roll < 90)
			r.position = POSITION_W'(gen_len + int'(r.action == ACT_INSERT));
		else
			r.position = POSITION_W'($urandom_range(127, 0));
		if ($urandom_range(1))
			r.value = val_pool[$urandom_range(VAL_POOL - 1, 0)];
		else
			r.value = $urandom;
		if (r.action == ACT_INSERT && gen_len < gen_cap && r.position <= gen_len)
			gen_len++;
		else if (r.action == ACT_REMOVE && gen_len > 0 && r.position < gen_len)
			gen_len--;
		return r;
	endfunction

	task automatic push_req(logic [ACTION_W-1:0] act, int pos, logic [VALUE_W-1:0] val);
		list_req_t r;
		r.action = act;
		r.position = pos[POSITION_W-1:0];
		r.value = val;
		pending_reqs.push_back(r);
	endtask

	// Waits until every request has been accepted and every result has arrived,
	// then waits on so that the block is surely idle.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// One phase: rewrite the capacity while idle, then queue a random batch.
	task automatic run_phase(int cap, int s_idle, int r_idle, int n, int ins_pct,
			int rem_pct, bit long_hold);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap[6:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		// The register took the word at this edge.
		list_capacity = cap;
		cfg_valid <= 1'b0;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		if (long_hold)
			hold_reqs++;
		gen_len = list_entries.size();
		gen_cap = (cap > DEPTH_DEF) ? DEPTH_DEF : cap;
		repeat (n)
			pending_reqs.push_back(make_request(ins_pct, rem_pct));
	endtask

	// Driver: a word is held on the bus until it is taken, then the next one is
	// offered unless the sender chooses to idle this cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_result(offered_req);
				action_seen[offered_req.action]++;
				req_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, offered_req.value, offered_req.position};
					s_axis_tuser <= offered_req.action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request so that
	// the block fills its output stage and has to stall its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_done) begin
			m_axis_tready <= 1'b0;
			hold_done <= hold_reqs;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		if (err_count < ERR_PRINT_MAX)
			$display("%0t ns result %0d: %s got 0x%0h, expected 0x%0h",
				$time, res_count, what, got, want);
		err_count++;
	endtask

	// Monitor: every result word taken is compared with the oldest prediction.
	always @(posedge clk) begin
		list_res_t e;
		list_res_t g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			g.status = m_axis_tuser;
			g.read_value = m_axis_tdata[31:0];
			g.found_position = m_axis_tdata[37:32];
			g.list_length = m_axis_tdata[44:38];
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected word, status", g.status, 0);
			end else begin
				e = expected_res.pop_front();
				if (g.status != e.status)
					report_mismatch("status", g.status, e.status);
				if (g.read_value != e.read_value)
					report_mismatch("read_value", g.read_value, e.read_value);
				if (g.found_position != e.found_position)
					report_mismatch("found_position", g.found_position, e.found_position);
				if (g.list_length != e.list_length)
					report_mismatch("list_length", g.list_length, e.list_length);
				if (e.status <= STS_NOTFOUND)
					status_seen[e.status]++;
			end
			res_count++;
		end
	end

	// Watchdog: counts cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, expected_res.size());
				$display("positional_array_list: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		val_pool[0] = '0;
		val_pool[1] = '1;
		for (int i = 2; i < VAL_POOL; i++)
			val_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity of 64, starting from an empty list.
		push_req(ACT_GET,    0,   32'h0);          // get on an empty list
		push_req(ACT_FIND,   0,   32'h0);          // find on an empty list
		push_req(ACT_REMOVE, 0,   32'h0);          // remove on an empty list
		push_req(ACT_REMOVE, 127, 32'h0);          // empty wins over a bad position
		push_req(ACT_INSERT, 1,   32'h1);          // insert beyond the length
		push_req(ACT_INSERT, 127, 32'h1);
		push_req(ACT_INSERT, 0,   32'h0000_0000);
		push_req(ACT_INSERT, 0,   32'hFFFF_FFFF);  // insert at the front
		push_req(ACT_INSERT, 2,   32'hA5A5_A5A5);  // insert at the end
		push_req(ACT_INSERT, 1,   32'h5A5A_5A5A);  // insert in the middle
		push_req(ACT_INSERT, 5,   32'h2);          // one past the end
		push_req(ACT_GET,    0,   32'h0);
		push_req(ACT_GET,    3,   32'h0);          // last entry
		push_req(ACT_GET,    4,   32'h0);          // get at the length
		push_req(ACT_GET,    127, 32'h0);
		push_req(ACT_FIND,   0,   32'h0000_0000);
		push_req(ACT_FIND,   0,   32'hFFFF_FFFF);
		push_req(ACT_FIND,   0,   32'h1234_5678);  // no match
		push_req(ACT_INSERT, 4,   32'hFFFF_FFFF);  // duplicate at the end
		push_req(ACT_FIND,   0,   32'hFFFF_FFFF);  // first of two matches
		push_req(ACT_REMOVE, 4,   32'h0);          // remove the last entry
		push_req(ACT_REMOVE, 4,   32'h0);          // now at the length
		push_req(ACT_REMOVE, 0,   32'h0);          // remove the first entry
		push_req(ACT_REMOVE, 127, 32'h0);
		push_req(ACT_FIND,   127, 32'h0000_0000);  // find ignores the position

		// Sender idles 35 %, receiver 48 % for the first phases, then the other
		// way round, then no idling at all. Capacities cover the smallest, zero
		// (every insert full), values above the store depth, a drop below the
		// current length and the full store.
		run_phase(1,   35, 48, 150, 40, 30, 1'b0);
		run_phase(0,   35, 48, 60,  40, 20, 1'b0);
		run_phase(127, 48, 35, 450, 60, 15, 1'b0);
		run_phase(5,   48, 35, 400, 20, 55, 1'b0);
		run_phase(64,  0,  0,  450, 55, 20, 1'b1);
		run_phase(33,  0,  0,  400, 35, 35, 1'b0);
		run_phase(2,   0,  0,  100, 40, 30, 1'b0);

		wait_drained();
		if (expected_res.size() != 0)
			report_mismatch("results never delivered", expected_res.size(), 0);

		$display("Ran %0d requests (get %0d, find %0d, insert %0d, remove %0d).",
			req_count, action_seen[ACT_GET], action_seen[ACT_FIND],
			action_seen[ACT_INSERT], action_seen[ACT_REMOVE]);
		$display("%0d results: ok %0d, full %0d, bad pos %0d, empty %0d, absent %0d; peak %0d.",
			res_count, status_seen[STS_OK], status_seen[STS_FULL],
			status_seen[STS_BADPOS], status_seen[STS_EMPTY],
			status_seen[STS_NOTFOUND], peak_length);
		if (err_count == 0)
			$display("positional_array_list: match");
		else
			$display("positional_array_list: mismatch");
		$finish;
	end

endmodule
